// ===== hdl/urm_pkg.sv =====
// ----------------------------------------------------------------------------
// urm_pkg
// types and constants shared by the unit id range merger modules
// ----------------------------------------------------------------------------
`default_nettype none

package urm_pkg;

   localparam int ID_W        = 8;
   localparam int LIM_W       = ID_W + 1;
   localparam int ENTRY_W     = 2 * ID_W;
   localparam int MAX_RESULTS = 32;
   localparam int OUT_CNT_W   = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND_SCAN,
      ST_FIND_DRAIN,
      ST_FIND_DONE,
      ST_EXT_SCAN,
      ST_EXT_DRAIN,
      ST_EXT_DONE,
      ST_EMIT
   } state_type;

   // sequencer to compare unit
   typedef struct packed {
      logic start_find;
      logic start_run;
      logic start_pass;
      logic data_valid;
      logic find_mode;
   } scan_ctl_type;

   // compare unit to sequencer
   typedef struct packed {
      logic             found;
      logic [ID_W-1:0]  best_b;
      logic [LIM_W-1:0] ce1;
      logic             changed;
   } scan_stat_type;

endpackage

`default_nettype wire

// ===== hdl/urm_ram.sv =====
// ----------------------------------------------------------------------------
// urm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module urm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/urm_scan_unit.sv =====
// ----------------------------------------------------------------------------
// urm_scan_unit
// shared compare unit: minimum search and run extension over stored ranges
// ----------------------------------------------------------------------------
`default_nettype none

module urm_scan_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire urm_pkg::scan_ctl_type         ctl,
   input  wire logic [urm_pkg::LIM_W-1:0]     lim,
   input  wire logic [urm_pkg::ENTRY_W-1:0]   entry,
   output urm_pkg::scan_stat_type             stat
);

   logic [urm_pkg::ID_W-1:0]  best_b_ff, best_b_in;
   logic [urm_pkg::LIM_W-1:0] ce1_ff, ce1_in;
   logic                      found_ff, found_in;
   logic                      changed_ff, changed_in;
   logic [urm_pkg::LIM_W-1:0] ent_b;
   logic [urm_pkg::LIM_W-1:0] ent_e;

   assign ent_b = {1'b0, entry[urm_pkg::ID_W-1:0]};
   assign ent_e = {1'b0, entry[urm_pkg::ENTRY_W-1:urm_pkg::ID_W]};

   always_comb begin
      best_b_in  = best_b_ff;
      ce1_in     = ce1_ff;
      found_in   = found_ff;
      changed_in = changed_ff;
      if (ctl.start_find) begin
         found_in = 1'b0;
      end
      if (ctl.start_run) begin
         ce1_in = {1'b0, best_b_ff};
      end
      if (ctl.start_pass) begin
         changed_in = 1'b0;
      end
      if (ctl.data_valid) begin
         if (ctl.find_mode) begin
            // smallest begin at or above the search limit
            if (ent_b >= lim && (!found_ff || ent_b[urm_pkg::ID_W-1:0] < best_b_ff)) begin
               best_b_in = ent_b[urm_pkg::ID_W-1:0];
               found_in  = 1'b1;
            end
         end else begin
            // overlapping or adjacent range pushes the run end out
            if (ent_b <= ce1_ff && ent_e >= ce1_ff) begin
               ce1_in     = ent_e + urm_pkg::LIM_W'(1);
               changed_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff   <= 1'b0;
         changed_ff <= 1'b0;
      end else begin
         found_ff   <= found_in;
         changed_ff <= changed_in;
      end
   end

   always_ff @(posedge clock) begin
      best_b_ff <= best_b_in;
      ce1_ff    <= ce1_in;
   end

   assign stat.found   = found_ff;
   assign stat.best_b  = best_b_ff;
   assign stat.ce1     = ce1_ff;
   assign stat.changed = changed_ff;

endmodule

`default_nettype wire

// ===== hdl/unit_id_range_merger.sv =====
// ----------------------------------------------------------------------------
// unit_id_range_merger
// collects unit id ranges and emits them merged into maximal ascending runs
// ----------------------------------------------------------------------------
// Each request transaction carries one 8-bit range; reversed bounds are
// swapped and the range is written to a store of MAX_RANGES entries (a full
// store drops the range and flags overflow for the whole set). After a
// non-last transaction the block stays idle and ready for the next. The
// transaction marked tlast starts the merge, during which req_tready is low:
// a sequencer drives one shared compare unit over the store, one entry read
// per cycle from the store ram. Each run needs one minimum-search pass plus
// extension passes until its end stops growing (at least two, as the first
// always pushes the end past the run's own range), and one further search
// pass ends the set; in the sending pass each run also goes through the
// emit state, where it waits out any response back-pressure.
// When MAX_RANGES exceeds 32 the runs are first counted in a full dry pass,
// so that overflow can be flagged on every response once more than 32 runs
// exist; only the first 32 are then sent. Responses leave through an output
// register, so the merge continues while a response waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module unit_id_range_merger #(
   parameter int MAX_RANGES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // range_begin [7:0], range_end [15:8]
   input  wire logic        req_tlast,   // set_last
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // merged_begin [7:0], merged_end [15:8]
   output logic             rsp_tlast,   // run_last
   output logic      [0:0]  rsp_tuser    // overflow [0]
);

   localparam int AW = MAX_RANGES > 1 ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   // a dry counting pass is only needed when runs can outnumber result slots
   localparam bit NEED_COUNT = MAX_RANGES > urm_pkg::MAX_RESULTS;

   localparam int IW = urm_pkg::ID_W;
   localparam int LW = urm_pkg::LIM_W;
   localparam int OW = urm_pkg::OUT_CNT_W;

   urm_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;        // ranges held in the store
   logic          ovf_seen_ff, ovf_seen_in;  // a range of this set was dropped
   logic [AW-1:0] scan_ff, scan_in;          // read address of the current pass
   logic          rd_vld_ff;                 // read data valid this cycle
   logic          rd_find_ff;                // read belongs to a search pass
   logic [LW-1:0] lim_ff, lim_in;            // next run starts at or above this
   logic          emit_mode_ff, emit_mode_in;
   logic [CW-1:0] run_cnt_ff, run_cnt_in;    // runs found in the counting pass
   logic [OW-1:0] out_cnt_ff, out_cnt_in;    // responses sent in this set
   logic          pend_vld_ff, pend_vld_in;  // a finished run waits to go out
   logic          emit_last_ff, emit_last_in;
   logic          trunc_ff, trunc_in;        // more runs than result slots
   logic [IW-1:0] pend_b_ff, pend_b_in;
   logic [IW-1:0] pend_e_ff, pend_e_in;

   // output register
   logic          rsp_vld_ff, rsp_vld_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   // store write side
   logic          wr_en;
   logic [IW-1:0] norm_b;
   logic [IW-1:0] norm_e;
   logic [urm_pkg::ENTRY_W-1:0] rd_data;

   logic          scan_last;

   urm_pkg::scan_ctl_type  ctl;
   urm_pkg::scan_stat_type stat;

   // swap reversed bounds
   always_comb begin
      if (req_tdata[7:0] > req_tdata[15:8]) begin
         norm_b = req_tdata[15:8];
         norm_e = req_tdata[7:0];
      end else begin
         norm_b = req_tdata[7:0];
         norm_e = req_tdata[15:8];
      end
   end

   assign scan_last = (CW'(scan_ff) + CW'(1)) == count_ff;

   urm_ram #(
      .WIDTH (urm_pkg::ENTRY_W),
      .DEPTH (MAX_RANGES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({norm_e, norm_b}),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   urm_scan_unit u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .lim   (lim_ff),
      .entry (rd_data),
      .stat  (stat)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_seen_in  = ovf_seen_ff;
      scan_in      = scan_ff;
      lim_in       = lim_ff;
      emit_mode_in = emit_mode_ff;
      run_cnt_in   = run_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      pend_vld_in  = pend_vld_ff;
      emit_last_in = emit_last_ff;
      trunc_in     = trunc_ff;
      pend_b_in    = pend_b_ff;
      pend_e_in    = pend_e_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      req_tready   = 1'b0;
      ctl          = '0;
      ctl.data_valid = rd_vld_ff;
      ctl.find_mode  = rd_find_ff;

      // response taken frees the output register
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         urm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (count_ff < CW'(MAX_RANGES)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_seen_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in       = urm_pkg::ST_FIND_SCAN;
                  scan_in        = '0;
                  lim_in         = '0;
                  emit_mode_in   = !NEED_COUNT;
                  run_cnt_in     = '0;
                  out_cnt_in     = '0;
                  pend_vld_in    = 1'b0;
                  trunc_in       = 1'b0;
                  ctl.start_find = 1'b1;
               end
            end
         end
         urm_pkg::ST_FIND_SCAN: begin
            if (scan_last) begin
               state_in = urm_pkg::ST_FIND_DRAIN;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         urm_pkg::ST_FIND_DRAIN: begin
            state_in = urm_pkg::ST_FIND_DONE;
         end
         urm_pkg::ST_FIND_DONE: begin
            if (stat.found) begin
               if (emit_mode_ff && pend_vld_ff) begin
                  // another run follows, so the waiting one is not the last
                  emit_last_in = 1'b0;
                  state_in     = urm_pkg::ST_EMIT;
               end else begin
                  ctl.start_run  = 1'b1;
                  ctl.start_pass = 1'b1;
                  scan_in        = '0;
                  state_in       = urm_pkg::ST_EXT_SCAN;
               end
            end else if (emit_mode_ff) begin
               emit_last_in = 1'b1;
               state_in     = urm_pkg::ST_EMIT;
            end else begin
               // counting done, start again and send
               emit_mode_in   = 1'b1;
               trunc_in       = int'(run_cnt_ff) > urm_pkg::MAX_RESULTS;
               lim_in         = '0;
               ctl.start_find = 1'b1;
               scan_in        = '0;
               state_in       = urm_pkg::ST_FIND_SCAN;
            end
         end
         urm_pkg::ST_EXT_SCAN: begin
            if (scan_last) begin
               state_in = urm_pkg::ST_EXT_DRAIN;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         urm_pkg::ST_EXT_DRAIN: begin
            state_in = urm_pkg::ST_EXT_DONE;
         end
         urm_pkg::ST_EXT_DONE: begin
            if (stat.changed) begin
               ctl.start_pass = 1'b1;
               scan_in        = '0;
               state_in       = urm_pkg::ST_EXT_SCAN;
            end else if (!emit_mode_ff) begin
               run_cnt_in     = run_cnt_ff + CW'(1);
               lim_in         = stat.ce1;
               ctl.start_find = 1'b1;
               scan_in        = '0;
               state_in       = urm_pkg::ST_FIND_SCAN;
            end else begin
               pend_vld_in = 1'b1;
               pend_b_in   = stat.best_b;
               pend_e_in   = IW'(stat.ce1 - LW'(1));
               if (out_cnt_ff == OW'(urm_pkg::MAX_RESULTS - 1)) begin
                  // last free result slot
                  emit_last_in = 1'b1;
                  state_in     = urm_pkg::ST_EMIT;
               end else begin
                  lim_in         = stat.ce1;
                  ctl.start_find = 1'b1;
                  scan_in        = '0;
                  state_in       = urm_pkg::ST_FIND_SCAN;
               end
            end
         end
         urm_pkg::ST_EMIT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {pend_e_ff, pend_b_ff};
               rsp_last_in = emit_last_ff;
               rsp_ovf_in  = ovf_seen_ff | trunc_ff;
               out_cnt_in  = out_cnt_ff + OW'(1);
               if (emit_last_ff) begin
                  count_in    = '0;
                  ovf_seen_in = 1'b0;
                  state_in    = urm_pkg::ST_IDLE;
               end else begin
                  ctl.start_run  = 1'b1;
                  ctl.start_pass = 1'b1;
                  scan_in        = '0;
                  state_in       = urm_pkg::ST_EXT_SCAN;
               end
            end
         end
         default: begin
            state_in = urm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= urm_pkg::ST_IDLE;
         count_ff     <= '0;
         ovf_seen_ff  <= 1'b0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rd_find_ff   <= 1'b0;
         lim_ff       <= '0;
         emit_mode_ff <= 1'b0;
         run_cnt_ff   <= '0;
         out_cnt_ff   <= '0;
         pend_vld_ff  <= 1'b0;
         emit_last_ff <= 1'b0;
         trunc_ff     <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_seen_ff  <= ovf_seen_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= (state_ff == urm_pkg::ST_FIND_SCAN) ||
                         (state_ff == urm_pkg::ST_EXT_SCAN);
         rd_find_ff   <= state_ff == urm_pkg::ST_FIND_SCAN;
         lim_ff       <= lim_in;
         emit_mode_ff <= emit_mode_in;
         run_cnt_ff   <= run_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         pend_vld_ff  <= pend_vld_in;
         emit_last_ff <= emit_last_in;
         trunc_ff     <= trunc_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      pend_b_ff   <= pend_b_in;
      pend_e_ff   <= pend_e_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

endmodule

`default_nettype wire

// ===== hdl/urm_checker.sv =====
// ----------------------------------------------------------------------------
// urm_checker
// port level checks for the unit id range merger
// ----------------------------------------------------------------------------
`default_nettype none

module urm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [0:0]  rsp_tuser
);

   // a stalled response holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // merged runs never come out reversed
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] <= rsp_tdata[15:8])
      else $error("merged run begin above end");

   // a set still being sent keeps the request side closed
   a_busy_mid_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request accepted while a set is still being sent");

   // the last range of a set starts the merge
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("ready straight after the last range of a set");

endmodule

bind unit_id_range_merger urm_checker u_urm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
